// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros, clocked on clk, off while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge out of reset.
`define RHH_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Antecedent at one edge implies consequent at the next edge.
`define RHH_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/rhh_pkg.sv =====
// ----------------------------------------------------------------------------
// rhh_pkg
// Types and constants shared by the Robin Hood insert unit.
// ----------------------------------------------------------------------------
package rhh_pkg;

    localparam int DEF_CAPACITY = 1024;
    localparam int DEF_KEY_BITS = 32;
    localparam int DEF_VAL_BITS = 32;

    // Fixed field widths of the stream payloads
    localparam int KEY_W    = 32;
    localparam int VALUE_W  = 32;
    localparam int HASH_W   = 32;
    localparam int STATUS_W = 2;
    localparam int TOTAL_W  = 11;
    localparam int IN_W     = KEY_W + VALUE_W + HASH_W;
    localparam int OUT_W    = 24;
    localparam int CFG_W    = 11;

    typedef enum logic [STATUS_W-1:0] {
        ST_INSERTED = 2'd0,
        ST_UPDATED  = 2'd1,
        ST_FULL     = 2'd2
    } status_t;

    typedef enum logic {
        REG_TABLE_SIZE  = 1'b0,
        REG_UPDATE_MODE = 1'b1
    } cfg_index_t;

endpackage

// ===== design/rhh_ram.sv =====
// ----------------------------------------------------------------------------
// rhh_ram
// Generic simple dual-port RAM, one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module rhh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ===== design/robin_hood_hash_insert_unit.sv =====
// ----------------------------------------------------------------------------
// robin_hood_hash_insert_unit
// Robin Hood open-addressed hash table, insert and update side.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one insert: key, value and an externally computed hash.
//   m_axis returns one result per insert: status (inserted / updated / full),
//   item count after the insert and number of buckets visited.
//   cfg writes table_size (index 0) and update_mode (index 1); write only
//   while the unit is idle. cfg is always ready.
// Operation:
//   One insert at a time. The start bucket is hash mod size, worked out one
//   hash bit per cycle. Then a read-only probe walk checks that the table
//   can take the key, and a second walk commits. Each probe is a RAM read
//   (S_READ) followed by an evaluate/write step (S_EVAL); the commit walk
//   is skipped when the first walk finds the table full.
// Reset:
//   After rst_n releases, the table RAM is swept clear, one bucket per cycle,
//   over all CAPACITY buckets; s_axis_tready stays low during that sweep.
// Stall:
//   A finished result sits in the output register until taken; the next
//   insert may be accepted meanwhile and waits at its end for the register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module robin_hood_hash_insert_unit #(
    parameter int CAPACITY = rhh_pkg::DEF_CAPACITY,
    parameter int KEY_BITS = rhh_pkg::DEF_KEY_BITS,
    parameter int VAL_BITS = rhh_pkg::DEF_VAL_BITS
) (
    input  logic                        clk,
    input  logic                        rst_n,
    // insert stream
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [rhh_pkg::IN_W-1:0]    s_axis_tdata,  // key, value, hash_value
    // result stream
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [rhh_pkg::OUT_W-1:0]   m_axis_tdata,  // status, item_total, probe_total
    // configuration writes
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic                        cfg_index,
    input  logic [rhh_pkg::CFG_W-1:0]   cfg_data
);

    localparam int ADDR_BITS = $clog2(CAPACITY);
    localparam int CNT_BITS  = $clog2(CAPACITY + 1);
    localparam int DIST_BITS = ADDR_BITS;
    localparam int ENTRY_W   = 1 + DIST_BITS + VAL_BITS + KEY_BITS;
    localparam int HBIT_W    = $clog2(rhh_pkg::HASH_W);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_MOD,
        S_READ,
        S_EVAL,
        S_FINISH
    } state_t;

    state_t                     state_reg;
    logic [ADDR_BITS-1:0]       clr_addr_reg;
    logic [rhh_pkg::CFG_W-1:0]  size_cfg_reg;
    logic                       mode_reg;
    logic [CNT_BITS-1:0]        size_reg;
    logic [CNT_BITS-1:0]        count_reg;
    // latched insert
    logic [KEY_BITS-1:0]        in_key_reg;
    logic [VAL_BITS-1:0]        in_val_reg;
    logic [rhh_pkg::HASH_W-1:0] hash_reg;
    logic [HBIT_W-1:0]          hbit_reg;
    logic [CNT_BITS-1:0]        rem_reg;
    logic [ADDR_BITS-1:0]       start_loc_reg;
    // walk state
    logic [KEY_BITS-1:0]        key_reg;
    logic [VAL_BITS-1:0]        val_reg;
    logic [DIST_BITS-1:0]       dist_reg;
    logic [ADDR_BITS-1:0]       loc_reg;
    logic [CNT_BITS-1:0]        probes_reg;
    logic                       commit_reg;
    rhh_pkg::status_t           res_status_reg;
    logic [CNT_BITS-1:0]        res_visited_reg;
    // output register
    logic                       out_valid_reg;
    logic [rhh_pkg::OUT_W-1:0]  out_data_reg;

    // RAM
    logic                       wr_en;
    logic [ADDR_BITS-1:0]       wr_addr;
    logic [ENTRY_W-1:0]         wr_data;
    logic [ENTRY_W-1:0]         rd_data;

    rhh_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (CAPACITY)
    ) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (loc_reg),
        .rd_data (rd_data)
    );

    // entry layout: {used, dist, value, key}
    logic                 r_used;
    logic [DIST_BITS-1:0] r_dist;
    logic [VAL_BITS-1:0]  r_val;
    logic [KEY_BITS-1:0]  r_key;
    assign {r_used, r_dist, r_val, r_key} = rd_data;

    logic                 key_hit;
    logic                 do_swap;
    logic [CNT_BITS-1:0]  probes_inc;
    logic                 loc_wrap;
    logic [VAL_BITS-1:0]  upd_val;
    logic [CNT_BITS:0]    rem_shift;
    logic [CNT_BITS:0]    rem_next;
    logic [CNT_BITS-1:0]  live_size;

    assign key_hit    = r_used && (r_key == key_reg);
    assign do_swap    = r_used && !key_hit && (dist_reg > r_dist);
    assign probes_inc = probes_reg + CNT_BITS'(1);
    assign loc_wrap   = (CNT_BITS'(loc_reg) + CNT_BITS'(1)) == size_reg;
    assign upd_val    = mode_reg ? (r_val + val_reg) : val_reg;

    // restoring remainder step, one hash bit per cycle
    assign rem_shift = {rem_reg, hash_reg[rhh_pkg::HASH_W-1]};
    assign rem_next  = (rem_shift >= {1'b0, size_reg})
                       ? (rem_shift - {1'b0, size_reg}) : rem_shift;

    // table_size: zero reads as one, above capacity saturates
    always_comb
    begin
        if (size_cfg_reg == '0)
        begin
            live_size = CNT_BITS'(1);
        end
        else if (32'(size_cfg_reg) > 32'(CAPACITY))
        begin
            live_size = CNT_BITS'(CAPACITY);
        end
        else
        begin
            live_size = CNT_BITS'(size_cfg_reg);
        end
    end

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = loc_reg;
        wr_data = {1'b1, dist_reg, val_reg, key_reg};
        if (state_reg == S_CLEAR)
        begin
            wr_en   = 1'b1;
            wr_addr = clr_addr_reg;
            wr_data = '0;
        end
        else if (state_reg == S_EVAL && commit_reg)
        begin
            if (!r_used || do_swap)
            begin
                wr_en = 1'b1;
            end
            else if (key_hit)
            begin
                wr_en   = 1'b1;
                wr_data = {1'b1, r_dist, upd_val, r_key};
            end
        end
    end

    assign s_axis_tready = (state_reg == S_IDLE);
    assign cfg_ready     = 1'b1;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_addr_reg  <= '0;
            size_cfg_reg  <= rhh_pkg::CFG_W'(1024);
            mode_reg      <= 1'b0;
            count_reg     <= '0;
            commit_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    rhh_pkg::REG_TABLE_SIZE:  size_cfg_reg <= cfg_data;
                    rhh_pkg::REG_UPDATE_MODE: mode_reg     <= cfg_data[0];
                    default: ;
                endcase
            end

            // in S_FINISH the register is reloaded on the same condition
            if (out_valid_reg && m_axis_tready && state_reg != S_FINISH)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_CLEAR:
                begin
                    clr_addr_reg <= clr_addr_reg + ADDR_BITS'(1);
                    if (clr_addr_reg == ADDR_BITS'(CAPACITY - 1))
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (s_axis_tvalid)
                    begin
                        in_key_reg <= KEY_BITS'(s_axis_tdata[31:0]);
                        in_val_reg <= VAL_BITS'(s_axis_tdata[63:32]);
                        hash_reg   <= s_axis_tdata[95:64];
                        hbit_reg   <= '0;
                        rem_reg    <= '0;
                        size_reg   <= live_size;
                        state_reg  <= S_MOD;
                    end
                end
                S_MOD:
                begin
                    rem_reg  <= rem_next[CNT_BITS-1:0];
                    hash_reg <= {hash_reg[rhh_pkg::HASH_W-2:0], 1'b0};
                    hbit_reg <= hbit_reg + HBIT_W'(1);
                    if (hbit_reg == HBIT_W'(rhh_pkg::HASH_W - 1))
                    begin
                        start_loc_reg <= ADDR_BITS'(rem_next);
                        loc_reg       <= ADDR_BITS'(rem_next);
                        key_reg       <= in_key_reg;
                        val_reg       <= in_val_reg;
                        dist_reg      <= '0;
                        probes_reg    <= '0;
                        commit_reg    <= 1'b0;
                        state_reg     <= S_READ;
                    end
                end
                S_READ:
                begin
                    state_reg <= S_EVAL;
                end
                S_EVAL:
                begin
                    if (!r_used || key_hit)
                    begin
                        res_status_reg  <= key_hit ? rhh_pkg::ST_UPDATED
                                                   : rhh_pkg::ST_INSERTED;
                        res_visited_reg <= probes_inc;
                        if (commit_reg)
                        begin
                            if (!r_used)
                            begin
                                count_reg <= count_reg + CNT_BITS'(1);
                            end
                            state_reg <= S_FINISH;
                        end
                        else
                        begin
                            // room confirmed: replay the walk with writes
                            loc_reg    <= start_loc_reg;
                            key_reg    <= in_key_reg;
                            val_reg    <= in_val_reg;
                            dist_reg   <= '0;
                            probes_reg <= '0;
                            commit_reg <= 1'b1;
                            state_reg  <= S_READ;
                        end
                    end
                    else
                    begin
                        if (do_swap)
                        begin
                            key_reg  <= r_key;
                            val_reg  <= r_val;
                            dist_reg <= r_dist + DIST_BITS'(1);
                        end
                        else
                        begin
                            dist_reg <= dist_reg + DIST_BITS'(1);
                        end
                        probes_reg <= probes_inc;
                        loc_reg    <= loc_wrap ? '0 : loc_reg + ADDR_BITS'(1);
                        if (probes_inc == size_reg)
                        begin
                            res_status_reg  <= rhh_pkg::ST_FULL;
                            res_visited_reg <= size_reg;
                            state_reg       <= S_FINISH;
                        end
                        else
                        begin
                            state_reg <= S_READ;
                        end
                    end
                end
                S_FINISH:
                begin
                    if (!out_valid_reg || m_axis_tready)
                    begin
                        out_valid_reg <= 1'b1;
                        out_data_reg  <= {rhh_pkg::TOTAL_W'(res_visited_reg),
                                          rhh_pkg::TOTAL_W'(count_reg),
                                          res_status_reg};
                        commit_reg    <= 1'b0;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // ---------------------------------------------------------------- checks
    `RHH_ASSERT(a_count_bound, count_reg <= CNT_BITS'(CAPACITY),
        "item count above capacity")
    `RHH_ASSERT(a_wr_states, !wr_en || state_reg == S_CLEAR || state_reg == S_EVAL,
        "stray table write")
    `RHH_ASSERT(a_probe_bound, state_reg != S_EVAL || probes_reg < size_reg,
        "probe past table size")
    `RHH_ASSERT_NEXT(a_commit_not_full, state_reg == S_EVAL && commit_reg,
        res_status_reg != rhh_pkg::ST_FULL || state_reg != S_FINISH,
        "commit walk found table full")

endmodule

// ===== verif/rhh_insert_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rhh_insert_checker
// Watches the insert, result and config channels of the Robin Hood insert
// unit, keeps a shadow hash table and checks every result transfer in order.
// ----------------------------------------------------------------------------
module rhh_insert_checker (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_axis_tvalid,
    input  logic                       s_axis_tready,
    input  logic [rhh_pkg::IN_W-1:0]   s_axis_tdata,
    input  logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    input  logic [rhh_pkg::OUT_W-1:0]  m_axis_tdata,
    input  logic                       cfg_valid,
    input  logic                       cfg_ready,
    input  logic                       cfg_index,
    input  logic [rhh_pkg::CFG_W-1:0]  cfg_data,
    output int                         outstanding,
    output int                         errors
);

    localparam int CAP = rhh_pkg::DEF_CAPACITY;

    // lowest bits first on the wire: status, item_total, probe_total
    typedef struct packed {
        logic [rhh_pkg::TOTAL_W-1:0]  probe_total;
        logic [rhh_pkg::TOTAL_W-1:0]  item_total;
        rhh_pkg::status_t             status;
    } insert_result_t;

    logic [rhh_pkg::KEY_W-1:0]   shadow_key  [CAP];
    logic [rhh_pkg::VALUE_W-1:0] shadow_val  [CAP];
    int unsigned                 shadow_dist [CAP];
    bit                          shadow_used [CAP];
    int unsigned                 occupied;
    logic [rhh_pkg::CFG_W-1:0]   table_size;
    logic                        add_mode;
    insert_result_t              result_q [$];

    // One probe walk; table is written only when commit is set.
    function automatic rhh_pkg::status_t probe_walk(
                                           input logic [rhh_pkg::KEY_W-1:0] k,
                                           input logic [rhh_pkg::VALUE_W-1:0] v,
                                           input logic [rhh_pkg::HASH_W-1:0] h,
                                           input bit commit,
                                           output int unsigned visited);
        int unsigned                 sz;
        int unsigned                 loc;
        int unsigned                 n;
        logic [rhh_pkg::KEY_W-1:0]   ck;
        logic [rhh_pkg::VALUE_W-1:0] cv;
        int unsigned                 cd;
        logic [rhh_pkg::KEY_W-1:0]   tk;
        logic [rhh_pkg::VALUE_W-1:0] tv;
        int unsigned                 td;
        sz = (table_size == 0) ? 1 : (table_size > CAP) ? CAP : table_size;
        loc = h % sz;
        ck = k;
        cv = v;
        cd = 0;
        for (n = 0; n < sz; n++)
        begin
            if (!shadow_used[loc])
            begin
                if (commit)
                begin
                    shadow_key[loc]  = ck;
                    shadow_val[loc]  = cv;
                    shadow_dist[loc] = cd;
                    shadow_used[loc] = 1'b1;
                    occupied++;
                end
                visited = n + 1;
                return rhh_pkg::ST_INSERTED;
            end
            if (shadow_key[loc] == ck)
            begin
                if (commit)
                    shadow_val[loc] = add_mode ? shadow_val[loc] + cv : cv;
                visited = n + 1;
                return rhh_pkg::ST_UPDATED;
            end
            // richer resident gives way to the poorer carried entry
            if (cd > shadow_dist[loc])
            begin
                tk = shadow_key[loc];
                tv = shadow_val[loc];
                td = shadow_dist[loc];
                if (commit)
                begin
                    shadow_key[loc]  = ck;
                    shadow_val[loc]  = cv;
                    shadow_dist[loc] = cd;
                end
                ck = tk;
                cv = tv;
                cd = td;
            end
            cd++;
            loc = (loc + 1 >= sz) ? 0 : loc + 1;
        end
        visited = sz;
        return rhh_pkg::ST_FULL;
    endfunction

    function automatic insert_result_t predict_insert(input logic [rhh_pkg::IN_W-1:0] d);
        insert_result_t   r;
        int unsigned      visited;
        rhh_pkg::status_t st;
        st = probe_walk(d[31:0], d[63:32], d[95:64], 1'b0, visited);
        if (st != rhh_pkg::ST_FULL)
            st = probe_walk(d[31:0], d[63:32], d[95:64], 1'b1, visited);
        r.status      = st;
        r.item_total  = occupied[rhh_pkg::TOTAL_W-1:0];
        r.probe_total = visited[rhh_pkg::TOTAL_W-1:0];
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        insert_result_t want;
        insert_result_t got;
        if (!rst_n)
        begin
            for (int i = 0; i < CAP; i++)
                shadow_used[i] = 1'b0;
            occupied    = 0;
            table_size  = CAP;
            add_mode    = 1'b0;
            result_q    = {};
            outstanding <= 0;
            errors      <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == rhh_pkg::REG_TABLE_SIZE)
                    table_size = cfg_data;
                else
                    add_mode = cfg_data[0];
            end
            // result first: a transfer at this edge cannot belong to an insert at it
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = m_axis_tdata;
                if (result_q.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, actual %h",
                             $time, m_axis_tdata);
                    errors <= errors + 1;
                end
                else
                begin
                    want = result_q.pop_front();
                    if (got.status !== want.status || got.item_total !== want.item_total
                        || got.probe_total !== want.probe_total)
                    begin
                        $display("%0t: result mismatch, expected st=%0d items=%0d probes=%0d,",
                                 $time, want.status, want.item_total, want.probe_total,
                                 " actual st=%0d items=%0d probes=%0d",
                                 got.status, got.item_total, got.probe_total);
                        errors <= errors + 1;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                result_q.push_back(predict_insert(s_axis_tdata));
            outstanding <= result_q.size();
        end
    end

endmodule

// ===== verif/tb_robin_hood_hash_insert_unit.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_robin_hood_hash_insert_unit
// Drives inserts and config writes into the Robin Hood insert unit, with
// random gaps and output stalls; the checker predicts and compares results.
// ----------------------------------------------------------------------------
module tb_robin_hood_hash_insert_unit;

    logic                      clk;
    logic                      rst_n;
    logic                      s_axis_tvalid;
    logic                      s_axis_tready;
    logic [rhh_pkg::IN_W-1:0]  s_axis_tdata;   // key, value, hash_value
    logic                      m_axis_tvalid;
    logic                      m_axis_tready;
    logic [rhh_pkg::OUT_W-1:0] m_axis_tdata;   // status, item_total, probe_total
    logic                      cfg_valid;
    logic                      cfg_ready;
    logic                      cfg_index;
    logic [rhh_pkg::CFG_W-1:0] cfg_data;
    int                        outstanding;
    int                        errors;
    bit                        gaps_on;        // per-phase switch: off removes the random input gaps and result stalls
    int                        sent;

    robin_hood_hash_insert_unit dut (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    rhh_insert_checker checker_i (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .outstanding(outstanding), .errors(errors)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        if (!gaps_on)
            return 0;
        if ($urandom_range(0, 9) < 6)
            return 0;
        if ($urandom_range(0, 9) < 8)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // result side back-pressure
    initial
    begin
        int n;
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            m_axis_tready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge clk);
            n = pick_gap();
            if (n > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (n) @(posedge clk);
            end
        end
    end

    task automatic write_reg(input rhh_pkg::cfg_index_t idx,
                             input logic [rhh_pkg::CFG_W-1:0] d);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // transfer one insert; valid stays high into the next one when no gap
    task automatic insert(input logic [31:0] k, input logic [31:0] v, input logic [31:0] h);
        int n;
        n = pick_gap();
        if (n > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (n) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {h, v, k};
        do @(posedge clk); while (!s_axis_tready);
        sent++;
    endtask

    // registers only change once every result is back
    task automatic set_table(input int size, input int add_mode);
        s_axis_tvalid <= 1'b0;
        // let the count take in the last accepted insert before it is polled
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (4) @(posedge clk);
        write_reg(rhh_pkg::REG_TABLE_SIZE, rhh_pkg::CFG_W'(size));
        write_reg(rhh_pkg::REG_UPDATE_MODE, rhh_pkg::CFG_W'(add_mode & 1));
    endtask

    initial
    begin
        int          sz;
        int          cnt;
        logic [31:0] k;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        cfg_valid     = 1'b0;
        cfg_index     = rhh_pkg::REG_TABLE_SIZE;
        cfg_data      = '0;
        gaps_on       = 1'b1;
        sent          = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // directed: four buckets, wrap, displacement, update, full refusal
        set_table(4, 0);
        insert(32'h0, 32'h0, 32'h0);
        insert(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        insert(32'h0, 32'h5, 32'h0);                  // replace
        insert(32'h1, 32'h11, 32'h0);                 // collides, shifts
        insert(32'h2, 32'h22, 32'h1);                 // passes a poorer resident, moves on
        insert(32'h3, 32'h33, 32'h2);                 // table full
        insert(32'h1, 32'h99, 32'h0);                 // update after probing
        set_table(4, 1);
        insert(32'h0, 32'hFFFF_FFFF, 32'h0);          // add with wrap
        insert(32'h2, 32'h1, 32'h1);
        set_table(0, 0);                              // zero acts as one bucket
        insert(32'h7, 32'h7, 32'h8000_0000);
        insert(32'h0, 32'h1234, 32'h3);
        set_table(1, 1);
        insert(32'h0, 32'h1, 32'hFFFF_FFFF);
        set_table(2047, 0);                           // clamps to capacity
        insert(32'hAAAA_5555, 32'h5555_AAAA, 32'hFFFF_FFFF);
        insert(32'h5555_AAAA, 32'hAAAA_5555, 32'd1023);
        set_table(1024, 1);
        insert(32'hAAAA_5555, 32'h1, 32'd2047);
        set_table(2, 0);                              // shrunk table keeps upper buckets
        insert(32'h8, 32'h8, 32'h0);
        insert(32'h9, 32'h9, 32'h1);
        insert(32'hA, 32'hA, 32'h1);

        // random phases, mostly small tables
        while (sent < 1050)
        begin
            case ($urandom_range(0, 15))
                0:       sz = 0;
                1:       sz = 1024;
                2:       sz = $urandom_range(1025, 2047);
                3:       sz = $urandom_range(65, 1023);
                4, 5:    sz = 1;
                default: sz = $urandom_range(2, 40);
            endcase
            gaps_on = ($urandom_range(0, 3) != 0);
            set_table(sz, $urandom_range(0, 1));
            cnt = $urandom_range(15, 70);
            repeat (cnt)
            begin
                // small keys repeat, so updates and steals are common
                k = ($urandom_range(0, 2) != 0) ? $urandom_range(0, 2 * sz + 4) : $urandom;
                insert(k, $urandom, ($urandom_range(0, 1) != 0) ? $urandom
                                                                   : $urandom_range(0, 63));
            end
        end

        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (200) @(posedge clk);
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // hang guard
    initial
    begin
        #500ms;
        $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+design
design/rhh_pkg.sv
design/rhh_ram.sv
design/robin_hood_hash_insert_unit.sv
verif/rhh_insert_checker.sv
verif/tb_robin_hood_hash_insert_unit.sv
